// File: rtl/rkc_pkg.sv
// ---------------------------------------------------------------------------
// rkc_pkg: shared types and constants for the range k-th smallest core
// Command and result structs, opcode and verdict codes, field widths.
// ---------------------------------------------------------------------------
package rkc_pkg;

    localparam int VAL_W   = 32;
    localparam int POS_W   = 10;
    localparam int RNG_W   = 11;
    localparam int CNT_W   = 11;
    localparam int VERD_W  = 2;
    localparam int DIFF_W  = VAL_W + 2;

    // sign bit flip maps signed order onto unsigned order
    localparam logic [VAL_W-1:0] SIGN_BIT = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [VERD_W-1:0] VERDICT_FIRST  = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_SECOND = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_TIE    = 2'd2;

    typedef struct packed {
        logic                     op;
        logic [POS_W-1:0]         load_position;
        logic signed [VAL_W-1:0]  load_value;
        logic [RNG_W-1:0]         range_first;
        logic [RNG_W-1:0]         range_last;
        logic [RNG_W-1:0]         rank;
        logic signed [VAL_W-1:0]  guess_first;
        logic signed [VAL_W-1:0]  guess_second;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0]  kth_value;
        logic [CNT_W-1:0]         match_count;
        logic [VERD_W-1:0]        verdict;
        logic                     query_error;
    } t_result;

endpackage

// File: rtl/rkc_ram.sv
// ---------------------------------------------------------------------------
// rkc_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ---------------------------------------------------------------------------
module rkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/range_kth_smallest_with_count_core.sv
// ---------------------------------------------------------------------------
// range_kth_smallest_with_count_core: k-th smallest value over a stored range
// Element store in a synchronous RAM, bitwise radix selection by range scans.
// ---------------------------------------------------------------------------
// Usage:
//   Present a command on i_cmd with start high; it transfers at a rising
//   edge where start is high and busy is low. A load command (op = 0) writes
//   one element in that edge and gives no result; busy stays low, so loads
//   may follow every cycle. A query command (op = 1) scans the range
//   [range_first, range_last] of the RAM once per value bit, most
//   significant first, then once more to count matches of the selected
//   value, then grades the two guesses against that count.
//   A valid query reads one range entry per cycle through the single RAM
//   read port, with a wait state closing each pass; a malformed query
//   reports query_error with o_done in the cycle after its transfer.
//   Throughput: one query at a time; busy is high while it runs.
//   o_done marks o_result for exactly one cycle; the receiver cannot stall.
//   Reset (synchronous, active low) returns the control to idle and drops
//   any query in flight; the element store is not cleared and entries are
//   undefined until loaded.
// ---------------------------------------------------------------------------
module range_kth_smallest_with_count_core #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rkc_pkg::t_cmd   i_cmd,
    output logic            o_done,
    output rkc_pkg::t_result o_result
);
    import rkc_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_DIFF = 3'd3;
    localparam logic [2:0] S_ABS  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;

    logic [2:0]               r_state;
    logic [AW-1:0]            r_addr;
    logic [AW-1:0]            r_lo;
    logic [AW-1:0]            r_hi;
    logic                     r_rd_vld;
    logic                     r_count_pass;
    logic [VAL_W-1:0]         r_prefix;
    logic [VAL_W-1:0]         r_mask;
    logic [VAL_W-1:0]         r_onehot;
    logic [CNT_W-1:0]         r_need;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_eq;
    logic signed [VAL_W-1:0]  r_g1;
    logic signed [VAL_W-1:0]  r_g2;
    logic signed [DIFF_W-1:0] r_d1;
    logic signed [DIFF_W-1:0] r_d2;
    logic                     r_done;
    t_result                  r_result;

    logic                     accept;
    logic                     load_we;
    logic                     bad_query;
    logic [RNG_W-1:0]         range_len;
    logic [VAL_W-1:0]         rd_data;
    logic [VAL_W-1:0]         biased;
    logic                     radix_hit;
    logic                     eq_hit;
    logic                     hit;
    logic [CNT_W-1:0]         cnt_next;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // drop loads aimed beyond the store
    assign load_we = accept && (i_cmd.op == OP_LOAD) &&
                     (32'(i_cmd.load_position) < STORE_DEPTH);

    // validate range and rank
    assign range_len = i_cmd.range_last - i_cmd.range_first + 11'd1;
    assign bad_query = (i_cmd.range_first == '0) ||
                       (32'(i_cmd.range_last) > STORE_DEPTH) ||
                       (i_cmd.range_first > i_cmd.range_last) ||
                       (i_cmd.rank == '0) ||
                       (i_cmd.rank > range_len);

    rkc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_cmd.load_position)),
        .i_wdata (i_cmd.load_value),
        .i_re    (r_state == S_SCAN),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // classify the element returned by the RAM
    assign biased    = rd_data ^ SIGN_BIT;
    assign radix_hit = ((biased & r_mask) == r_prefix) && ((biased & r_onehot) == '0);
    assign eq_hit    = (rd_data == (r_prefix ^ SIGN_BIT));
    assign hit       = r_count_pass ? eq_hit : radix_hit;
    assign cnt_next  = r_cnt + CNT_W'(hit);

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
            r_done   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_cmd.op == OP_QUERY)) begin
                        if (bad_query) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_addr == r_hi) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= r_count_pass ? S_DIFF : S_SCAN;
                end
                S_DIFF: r_state <= S_ABS;
                S_ABS:  r_state <= S_CMP;
                S_CMP: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // selection datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_lo         <= AW'(i_cmd.range_first - 11'd1);
                r_hi         <= AW'(i_cmd.range_last - 11'd1);
                r_addr       <= AW'(i_cmd.range_first - 11'd1);
                r_need       <= i_cmd.rank;
                r_g1         <= i_cmd.guess_first;
                r_g2         <= i_cmd.guess_second;
                r_prefix     <= '0;
                r_mask       <= '0;
                r_onehot     <= SIGN_BIT;
                r_cnt        <= '0;
                r_count_pass <= 1'b0;
            end
            S_SCAN: begin
                // advance the read pointer and count the returning element
                r_addr <= r_addr + AW'(1);
                if (r_rd_vld) begin
                    r_cnt <= cnt_next;
                end
            end
            S_WAIT: begin
                // close the pass with its last element
                r_cnt  <= '0;
                r_addr <= r_lo;
                if (r_count_pass) begin
                    r_eq <= cnt_next;
                end else begin
                    if (r_need > cnt_next) begin
                        r_need   <= r_need - cnt_next;
                        r_prefix <= r_prefix | r_onehot;
                    end
                    r_mask   <= r_mask | r_onehot;
                    r_onehot <= r_onehot >> 1;
                    if (r_onehot[0]) begin
                        r_count_pass <= 1'b1;
                    end
                end
            end
            S_DIFF: begin
                r_d1 <= DIFF_W'(r_g1) - DIFF_W'(signed'({1'b0, r_eq}));
                r_d2 <= DIFF_W'(r_g2) - DIFF_W'(signed'({1'b0, r_eq}));
            end
            S_ABS: begin
                r_d1 <= r_d1[DIFF_W-1] ? -r_d1 : r_d1;
                r_d2 <= r_d2[DIFF_W-1] ? -r_d2 : r_d2;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_result <= '{kth_value: '0, match_count: '0, verdict: VERDICT_FIRST,
                          query_error: 1'b1};
        end else if (r_state == S_CMP) begin
            r_result.kth_value   <= r_prefix ^ SIGN_BIT;
            r_result.match_count <= r_eq;
            r_result.query_error <= 1'b0;
            if ($unsigned(r_d1) < $unsigned(r_d2)) begin
                r_result.verdict <= VERDICT_FIRST;
            end else if ($unsigned(r_d1) > $unsigned(r_d2)) begin
                r_result.verdict <= VERDICT_SECOND;
            end else begin
                r_result.verdict <= VERDICT_TIE;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: rtl/rkc_chk.sv
// ---------------------------------------------------------------------------
// rkc_chk: port-level checks for the range k-th smallest core
// Watches transfers and result strobes; attached to the top level by bind.
// ---------------------------------------------------------------------------
module rkc_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input rkc_pkg::t_cmd    i_cmd,
    input logic             o_done,
    input rkc_pkg::t_result o_result
);
    import rkc_pkg::*;

    // a failed query carries zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.query_error |->
            o_result.kth_value == '0 && o_result.match_count == '0 &&
            o_result.verdict == VERDICT_FIRST)
        else $error("failed query with nonzero payload");

    // the selected value occurs in its range at least once
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.query_error |-> o_result.match_count != '0)
        else $error("answered query with zero match count");

    // a malformed range is answered in the next cycle
    a_bad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.op == OP_QUERY &&
        (i_cmd.range_first == '0 || i_cmd.range_first > i_cmd.range_last)
        |=> o_done && o_result.query_error)
        else $error("malformed range not flagged");

    // a load transfer never yields a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.op == OP_LOAD |=> !o_done)
        else $error("result after a load");

    // the result strobe lands once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

endmodule

bind range_kth_smallest_with_count_core rkc_chk u_rkc_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_done   (o_done),
    .o_result (o_result)
);

// File: dv/range_kth_smallest_with_count_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// range_kth_smallest_with_count_core_tb: self-checking bench for the core
// Loads elements and issues range queries through the start/busy handshake.
// A directed table opens the run, a low store window is then filled, and
// random traffic follows in three phases of sender idling, every well-formed
// query inside written entries. Answers are checked field by field against
// directed rows or an order-statistic predictor over a mirror of the store.
// ---------------------------------------------------------------------------
module range_kth_smallest_with_count_core_tb;
    import rkc_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WINDOW = 32;
    localparam int ROUND_ITEMS = 18;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam t_result REFUSED = '{kth_value: '0, match_count: '0, verdict: '0,
                                    query_error: 1'b1};
    localparam t_result UNTYPED = '0;

    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd    i_cmd = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    logic signed [VAL_W-1:0] elem_mirror [DEPTH];
    bit                      loaded [DEPTH];
    t_result                 awaited_answers [$];
    t_dir_row                dir_table [$];
    int                      mismatch_count = 0;
    int                      send_gap_pct = 6;

    range_kth_smallest_with_count_core #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // k-th smallest by rank bracketing: an element e is the answer when
    // fewer than rank entries lie below it and at least rank lie at or below
    function automatic t_result solve_range_query(input t_cmd c);
        t_result r;
        int first, last, rank, less, leq, cnt;
        logic signed [VAL_W-1:0] pick;
        longint d1, d2;
        r = '0;
        cnt = 0;
        first = int'(c.range_first);
        last = int'(c.range_last);
        rank = int'(c.rank);
        if (first == 0 || last > DEPTH || first > last || rank == 0 ||
            rank > last - first + 1) begin
            return REFUSED;
        end
        for (int i = first - 1; i < last; i++) begin
            pick = elem_mirror[i];
            less = 0;
            leq = 0;
            for (int j = first - 1; j < last; j++) begin
                if (elem_mirror[j] < pick) less++;
                if (elem_mirror[j] <= pick) leq++;
            end
            if (less < rank && rank <= leq) begin
                r.kth_value = pick;
                cnt = leq - less;
                break;
            end
        end
        r.match_count = CNT_W'(cnt);
        // grade guesses on exact 64-bit distances
        d1 = longint'($signed(c.guess_first)) - longint'(cnt);
        d2 = longint'($signed(c.guess_second)) - longint'(cnt);
        if (d1 < 0) d1 = -d1;
        if (d2 < 0) d2 = -d2;
        if (d1 < d2) r.verdict = VERDICT_FIRST;
        else if (d1 > d2) r.verdict = VERDICT_SECOND;
        else r.verdict = VERDICT_TIE;
        return r;
    endfunction

    function automatic t_dir_row row(input logic op, input int pos, input int val,
                                     input int first, input int last, input int rank,
                                     input int g1, input int g2, input bit typed,
                                     input t_result want);
        t_dir_row d;
        d.cmd = '0;
        d.cmd.op = op;
        d.cmd.load_position = POS_W'(pos);
        d.cmd.load_value = val;
        d.cmd.range_first = RNG_W'(first);
        d.cmd.range_last = RNG_W'(last);
        d.cmd.rank = RNG_W'(rank);
        d.cmd.guess_first = g1;
        d.cmd.guess_second = g2;
        d.typed = typed;
        d.want = want;
        return d;
    endfunction

    // fill every field at random; callers overwrite what matters
    function automatic t_cmd noise_cmd();
        t_cmd c;
        c.op = 1'($urandom);
        c.load_position = POS_W'($urandom);
        c.load_value = $urandom;
        c.range_first = RNG_W'($urandom);
        c.range_last = RNG_W'($urandom);
        c.rank = RNG_W'($urandom);
        c.guess_first = $urandom;
        c.guess_second = $urandom;
        return c;
    endfunction

    // favor a small pool so ranges hold repeated values
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9)) inside
            0: return VAL_MIN;
            1: return VAL_MAX;
            [2:4]: return $urandom;
            default: return $urandom_range(0, 8) - 4;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_guess();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 12) - 2;
    endfunction

    function automatic t_cmd load_cmd(input int pos);
        t_cmd c;
        c = noise_cmd();
        c.op = OP_LOAD;
        c.load_position = POS_W'(pos);
        c.load_value = pick_value();
        return c;
    endfunction

    // a well-formed query that stays inside the written window
    function automatic t_cmd valid_query(input int len);
        t_cmd c;
        c = noise_cmd();
        c.op = OP_QUERY;
        c.range_first = RNG_W'($urandom_range(1, WINDOW - len + 1));
        c.range_last = RNG_W'(int'(c.range_first) + len - 1);
        case ($urandom_range(0, 3))
            0: c.rank = RNG_W'(1);
            1: c.rank = RNG_W'(len);
            default: c.rank = RNG_W'($urandom_range(1, len));
        endcase
        c.guess_first = pick_guess();
        c.guess_second = ($urandom_range(0, 4) == 0) ? c.guess_first : pick_guess();
        return c;
    endfunction

    function automatic t_cmd bad_query();
        t_cmd c;
        int first, last;
        c = noise_cmd();
        c.op = OP_QUERY;
        first = $urandom_range(1, DEPTH);
        last = $urandom_range(first, DEPTH);
        case ($urandom_range(0, 4))
            0: c.range_first = '0;
            1: begin
                c.range_first = RNG_W'(first);
                c.range_last = RNG_W'($urandom_range(DEPTH + 1, 2047));
            end
            2: begin
                c.range_last = RNG_W'($urandom_range(1, DEPTH - 1));
                c.range_first = RNG_W'($urandom_range(int'(c.range_last) + 1, 2047));
            end
            3: begin
                c.range_first = RNG_W'(first);
                c.range_last = RNG_W'(last);
                c.rank = '0;
            end
            default: begin
                c.range_first = RNG_W'(first);
                c.range_last = RNG_W'(last);
                c.rank = RNG_W'($urandom_range(last - first + 2, 2047));
            end
        endcase
        return c;
    endfunction

    // present one command, hold it until it transfers, then record its effect
    task automatic send_cmd(input t_cmd c, input bit typed, input t_result want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        if (c.op == OP_LOAD) begin
            elem_mirror[c.load_position] = c.load_value;
            loaded[c.load_position] = 1'b1;
        end else begin
            awaited_answers.push_back(typed ? want : solve_range_query(c));
        end
    endtask

    // stop sending until every pending answer is back
    task automatic drain_answers();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_answers.size() != 0);
    endtask

    // compare each answer against the oldest pending one
    always @(posedge i_clk) begin : check_answers
        t_result want;
        if (i_rst_n && o_done) begin
            if (awaited_answers.size() == 0) begin
                $display("%0t: unexpected answer %p", $time, o_result);
                mismatch_count++;
            end else begin
                want = awaited_answers.pop_front();
                if (o_result.kth_value !== want.kth_value) begin
                    $display("%0t: kth_value expected %0d, got %0d", $time,
                             want.kth_value, o_result.kth_value);
                    mismatch_count++;
                end
                if (o_result.match_count !== want.match_count) begin
                    $display("%0t: match_count expected %0d, got %0d", $time,
                             want.match_count, o_result.match_count);
                    mismatch_count++;
                end
                if (o_result.verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d, got %0d", $time,
                             want.verdict, o_result.verdict);
                    mismatch_count++;
                end
                if (o_result.query_error !== want.query_error) begin
                    $display("%0t: query_error expected %0d, got %0d", $time,
                             want.query_error, o_result.query_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_cmd c;
        int kind;

        // directed rows: refused queries, extreme loads, small known ranges
        dir_table.push_back(row(OP_QUERY, 0, 0, 0, 5, 1, 0, 0, 1, REFUSED));
        dir_table.push_back(row(OP_QUERY, 0, 0, 3, 2, 1, 0, 0, 1, REFUSED));
        dir_table.push_back(row(OP_QUERY, 0, 0, 1, DEPTH + 1, 1, 0, 0, 1, REFUSED));
        dir_table.push_back(row(OP_QUERY, 0, 0, 1, 4, 0, 0, 0, 1, REFUSED));
        dir_table.push_back(row(OP_QUERY, 0, 0, 1, 4, 5, 0, 0, 1, REFUSED));
        dir_table.push_back(row(OP_QUERY, 1023, -1, 2047, 2047, 2047, -1, -1, 1,
                                REFUSED));
        dir_table.push_back(row(OP_LOAD, 0, VAL_MIN, 0, 0, 0, 0, 0, 0, UNTYPED));
        dir_table.push_back(row(OP_LOAD, 1, VAL_MAX, 0, 0, 0, 0, 0, 0, UNTYPED));
        dir_table.push_back(row(OP_LOAD, 2, 0, 0, 0, 0, 0, 0, 0, UNTYPED));
        dir_table.push_back(row(OP_LOAD, 3, -1, 0, 0, 0, 0, 0, 0, UNTYPED));
        dir_table.push_back(row(OP_LOAD, 4, VAL_MIN, 0, 0, 0, 0, 0, 0, UNTYPED));
        dir_table.push_back(row(OP_LOAD, DEPTH - 1, VAL_MAX, 0, 0, 0, 0, 0, 0,
                                UNTYPED));
        dir_table.push_back(row(OP_LOAD, DEPTH - 2, 7, 0, 0, 0, 0, 0, 0, UNTYPED));
        dir_table.push_back(row(OP_QUERY, 0, 0, 1, 1, 1, 1, 0, 1,
                                t_result'{VAL_MIN, 11'd1, VERDICT_FIRST, 1'b0}));
        dir_table.push_back(row(OP_QUERY, 0, 0, 1, 5, 1, 0, 2, 1,
                                t_result'{VAL_MIN, 11'd2, VERDICT_SECOND, 1'b0}));
        dir_table.push_back(row(OP_QUERY, 0, 0, 1, 5, 5, VAL_MIN, VAL_MAX, 0,
                                UNTYPED));
        dir_table.push_back(row(OP_QUERY, 0, 0, 1, 5, 3, 0, 2, 1,
                                t_result'{-32'sd1, 11'd1, VERDICT_TIE, 1'b0}));
        dir_table.push_back(row(OP_QUERY, 0, 0, DEPTH, DEPTH, 1, VAL_MAX, VAL_MAX, 1,
                                t_result'{VAL_MAX, 11'd1, VERDICT_TIE, 1'b0}));
        dir_table.push_back(row(OP_QUERY, 0, 0, DEPTH - 1, DEPTH, 2, VAL_MIN, -5, 0,
                                UNTYPED));
        dir_table.push_back(row(OP_QUERY, 0, 0, 1, 2, 2, 1, 1, 0, UNTYPED));
        dir_table.push_back(row(OP_QUERY, 0, 0, 3, 4, 1, 3, -1, 0, UNTYPED));

        // hold reset, then release
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k]) send_cmd(dir_table[k].cmd, dir_table[k].typed,
                                        dir_table[k].want);
        drain_answers();

        // write the low window so any range inside it may be queried
        for (int p = 0; p < WINDOW; p++) begin
            if (!loaded[p]) send_cmd(load_cmd(p), 1'b0, UNTYPED);
        end

        // random traffic in three rounds of sender idling
        for (int round = 0; round < 3; round++) begin
            send_gap_pct = (round == 0) ? 6 : (round == 1) ? 62 : 0;
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                kind = $urandom_range(0, 9);
                if (round == 0 && n < 2) begin
                    c = valid_query(WINDOW);
                    c.rank = (n == 0) ? RNG_W'(1) : RNG_W'(WINDOW);
                end else if (round == 1 && n == 0) begin
                    c = valid_query(WINDOW);
                end else if (kind < 4) begin
                    c = load_cmd($urandom_range(0, WINDOW - 1));
                end else if (kind < 9) begin
                    c = valid_query($urandom_range(1, WINDOW));
                end else begin
                    c = bad_query();
                end
                send_cmd(c, 1'b0, UNTYPED);
            end
            drain_answers();
        end

        // allow stray answers to show up
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("range_kth_smallest_with_count_core_tb passed");
        end else begin
            $display("range_kth_smallest_with_count_core_tb failed");
        end
        $finish;
    end

    // abort a hung run
    initial begin
        #50_000_000;
        $display("range_kth_smallest_with_count_core_tb failed");
        $finish;
    end

endmodule
